// ----- rtl/temperature_alarm_hysteresis_fsm_assert.svh -----
// ---------------------------------------------------------------------------
// Temperature alarm assertion macros
// Short forms for the concurrent checks used in the alarm block.
// ---------------------------------------------------------------------------
`ifndef TEMPERATURE_ALARM_HYSTERESIS_FSM_ASSERT_SVH
`define TEMPERATURE_ALARM_HYSTERESIS_FSM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TAH_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TAH_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tah_pkg.sv -----
// ---------------------------------------------------------------------------
// Temperature alarm package
// Shared codes, reset values and the types passed between the alarm modules.
// ---------------------------------------------------------------------------
package tah_pkg;

  localparam int unsigned TempWidth  = 16;
  localparam int unsigned CfgAddrW   = 4;
  localparam int unsigned CfgDataW   = 32;

  // Register indexes on the configuration port (byte address is 4 * index).
  typedef enum logic [1:0] {
    REG_HIGH_CRIT = 2'd0,
    REG_HIGH_WARN = 2'd1,
    REG_LOW_WARN  = 2'd2,
    REG_LOW_CRIT  = 2'd3
  } tah_reg_e_t;

  // Threshold reset values.
  localparam logic signed [TempWidth-1:0] HighCritReset = 16'sd100;
  localparam logic signed [TempWidth-1:0] HighWarnReset = 16'sd80;
  localparam logic signed [TempWidth-1:0] LowWarnReset  = 16'sd10;
  localparam logic signed [TempWidth-1:0] LowCritReset  = 16'sd0;

  // Alarm event codes.
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_HI_WARN = 3'd1,
    EV_LO_WARN = 3'd2,
    EV_HI_CRIT = 3'd3,
    EV_LO_CRIT = 3'd4
  } tah_event_t;

  // LED mode codes.
  typedef enum logic [1:0] {
    LED_NORMAL   = 2'd0,
    LED_WARNING  = 2'd1,
    LED_CRITICAL = 2'd2,
    LED_KEEP     = 2'd3
  } tah_led_t;

  // Input kind codes.
  typedef enum logic {
    KIND_READING = 1'b0,
    KIND_RESTART = 1'b1
  } tah_kind_t;

  // The four thresholds as seen by the state machine.
  typedef struct packed {
    logic signed [TempWidth-1:0] high_crit;
    logic signed [TempWidth-1:0] high_warn;
    logic signed [TempWidth-1:0] low_warn;
    logic signed [TempWidth-1:0] low_crit;
  } tah_limits_t;

  // One result: LED mode above the alarm event, as packed on the output bus.
  typedef struct packed {
    tah_led_t   led_mode;
    tah_event_t alarm_event;
  } tah_result_t;

  localparam int unsigned ResultW = $bits(tah_result_t);
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

endpackage

// ----- rtl/tah_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// Temperature alarm threshold registers
// APB-style register file holding the four signed alarm thresholds.
// ---------------------------------------------------------------------------
module tah_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tah_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [tah_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [tah_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                          cfg_pready,
  output tah_pkg::tah_limits_t          limits
);
  import tah_pkg::*;

  tah_limits_t limits_r;
  tah_limits_t limits_nxt;
  tah_reg_e_t  reg_sel;
  logic        wr_en;
  logic signed [TempWidth-1:0] rd_val;

  assign cfg_pready = 1'b1;
  assign reg_sel    = tah_reg_e_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Write decode.
  always_comb begin
    limits_nxt = limits_r;
    if (wr_en) begin
      case (reg_sel)
        REG_HIGH_CRIT: limits_nxt.high_crit = cfg_pwdata[TempWidth-1:0];
        REG_HIGH_WARN: limits_nxt.high_warn = cfg_pwdata[TempWidth-1:0];
        REG_LOW_WARN:  limits_nxt.low_warn  = cfg_pwdata[TempWidth-1:0];
        REG_LOW_CRIT:  limits_nxt.low_crit  = cfg_pwdata[TempWidth-1:0];
        default:       limits_nxt = limits_r;
      endcase
    end
  end

  // Threshold storage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.high_crit <= HighCritReset;
      limits_r.high_warn <= HighWarnReset;
      limits_r.low_warn  <= LowWarnReset;
      limits_r.low_crit  <= LowCritReset;
    end else begin
      limits_r <= limits_nxt;
    end
  end

  // Read back, sign-extended to the bus width.
  always_comb begin
    case (reg_sel)
      REG_HIGH_CRIT: rd_val = limits_r.high_crit;
      REG_HIGH_WARN: rd_val = limits_r.high_warn;
      REG_LOW_WARN:  rd_val = limits_r.low_warn;
      REG_LOW_CRIT:  rd_val = limits_r.low_crit;
      default:       rd_val = limits_r.high_crit;
    endcase
  end

  assign cfg_prdata = CfgDataW'(rd_val);
  assign limits     = limits_r;

endmodule

// ----- rtl/tah_fsm.sv -----
// ---------------------------------------------------------------------------
// Temperature alarm state machine
// Nine-state hysteresis machine; computes the event and LED mode per reading.
// ---------------------------------------------------------------------------
module tah_fsm (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  tah_pkg::tah_kind_t                  kind,
  input  logic signed [tah_pkg::TempWidth-1:0] temperature,
  input  tah_pkg::tah_limits_t                limits,
  output tah_pkg::tah_result_t                result
);
  import tah_pkg::*;

  typedef enum logic [3:0] {
    ST_NORM_INIT    = 4'd0,
    ST_NORM_FROM_LO = 4'd1,
    ST_NORM_FROM_HI = 4'd2,
    ST_HI_WARN_A    = 4'd3,
    ST_HI_WARN_B    = 4'd4,
    ST_HI_CRIT      = 4'd5,
    ST_LO_WARN_A    = 4'd6,
    ST_LO_WARN_B    = 4'd7,
    ST_LO_CRIT      = 4'd8
  } state_t;

  state_t     state_r;
  state_t     state_nxt;
  tah_event_t ev;
  tah_led_t   led;
  logic       ge_hc;
  logic       ge_hw;
  logic       le_lw;
  logic       le_lc;

  // Threshold compares, shared by all states.
  assign ge_hc = temperature >= limits.high_crit;
  assign ge_hw = temperature >= limits.high_warn;
  assign le_lw = temperature <= limits.low_warn;
  assign le_lc = temperature <= limits.low_crit;

  // Next state and result for the current request.
  always_comb begin
    state_nxt = state_r;
    ev        = EV_NONE;
    led       = LED_KEEP;
    if (kind == KIND_RESTART) begin
      state_nxt = ST_NORM_INIT;
    end else begin
      case (state_r)
        ST_NORM_FROM_LO: begin
          if (ge_hw) begin
            state_nxt = ST_HI_WARN_A;
            ev        = EV_HI_WARN;
            led       = LED_WARNING;
          end else if (le_lw) begin
            // Coming back from low: no repeated low warning.
            state_nxt = ST_LO_WARN_A;
            led       = LED_WARNING;
          end else begin
            led = LED_NORMAL;
          end
        end
        ST_NORM_FROM_HI: begin
          if (le_lw) begin
            state_nxt = ST_LO_WARN_A;
            ev        = EV_LO_WARN;
            led       = LED_WARNING;
          end else if (ge_hw) begin
            // Coming back from high: no repeated high warning.
            state_nxt = ST_HI_WARN_A;
            led       = LED_WARNING;
          end else begin
            led = LED_NORMAL;
          end
        end
        ST_HI_WARN_A, ST_HI_WARN_B: begin
          if (ge_hc) begin
            if (state_r == ST_HI_WARN_A) begin
              ev = EV_HI_CRIT;
            end
            state_nxt = ST_HI_CRIT;
            led       = LED_CRITICAL;
          end else if (!ge_hw) begin
            state_nxt = ST_NORM_FROM_HI;
            led       = LED_NORMAL;
          end else begin
            led = LED_WARNING;
          end
        end
        ST_HI_CRIT: begin
          if (!ge_hc) begin
            state_nxt = ST_HI_WARN_B;
            led       = LED_WARNING;
          end else begin
            led = LED_CRITICAL;
          end
        end
        ST_LO_WARN_A, ST_LO_WARN_B: begin
          if (le_lc) begin
            if (state_r == ST_LO_WARN_A) begin
              ev = EV_LO_CRIT;
            end
            state_nxt = ST_LO_CRIT;
            led       = LED_CRITICAL;
          end else if (!le_lw) begin
            state_nxt = ST_NORM_FROM_LO;
            led       = LED_NORMAL;
          end else begin
            led = LED_WARNING;
          end
        end
        ST_LO_CRIT: begin
          if (!le_lc) begin
            state_nxt = ST_LO_WARN_B;
            led       = LED_WARNING;
          end else begin
            led = LED_CRITICAL;
          end
        end
        default: begin
          // Initial normal state, and any unused code.
          if (ge_hw) begin
            state_nxt = ST_HI_WARN_A;
            ev        = EV_HI_WARN;
            led       = LED_WARNING;
          end else if (le_lw) begin
            state_nxt = ST_LO_WARN_A;
            ev        = EV_LO_WARN;
            led       = LED_WARNING;
          end else begin
            state_nxt = ST_NORM_INIT;
          end
        end
      endcase
    end
  end

  // State register, advanced once per accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_NORM_INIT;
    end else if (step) begin
      state_r <= state_nxt;
    end
  end

  assign result.alarm_event = ev;
  assign result.led_mode    = led;

endmodule

// ----- rtl/tah_out_skid.sv -----
// ---------------------------------------------------------------------------
// Temperature alarm result buffer
// Output register with one skid entry, so the input ready is registered.
// ---------------------------------------------------------------------------
module tah_out_skid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tah_pkg::tah_result_t push_data,
  output logic                 can_push,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tah_pkg::tah_result_t out_data
);
  import tah_pkg::*;

  logic        out_valid_r;
  logic        skid_valid_r;
  tah_result_t out_data_r;
  tah_result_t skid_data_r;
  logic        pop;

  assign pop = out_valid_r && out_ready;

  // Control: the skid entry fills only when the output register is held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      if (out_valid_r) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      if (out_valid_r) begin
        skid_data_r <= push_data;
      end else begin
        out_data_r <= push_data;
      end
    end
  end

  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/temperature_alarm_hysteresis_fsm.sv -----
// ---------------------------------------------------------------------------
// Temperature alarm with hysteresis
// Each result is registered in the output register, or in the skid entry while the output is held.
// Throughput: 1 reading per cycle while in_tready is high; the state register updates in one pass.
// in_tready is registered: it drops only while the one-entry skid is full.
// Reset (synchronous, rst_n low): state to initial normal, thresholds to
// 100 / 80 / 10 / 0, result buffer empty.
// ---------------------------------------------------------------------------
`include "temperature_alarm_hysteresis_fsm_assert.svh"

module temperature_alarm_hysteresis_fsm (
  input  logic                          clk,
  input  logic                          rst_n,
  // Reading channel.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [15:0] temperature
  input  logic                          in_tuser,   // [0] kind
  // Result channel.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tah_pkg::OutDataW-1:0]  out_tdata,  // [2:0] alarm_event,
                                                    // [4:3] led_mode, rest 0
  // Configuration port.
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tah_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [tah_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [tah_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);
  import tah_pkg::*;

  tah_limits_t limits;
  tah_result_t step_result;
  tah_result_t out_result;
  logic        in_accept;

  assign in_accept = in_tvalid && in_tready;

  // Threshold registers.
  tah_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .limits      (limits)
  );

  // Hysteresis state machine.
  tah_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_accept),
    .kind        (tah_kind_t'(in_tuser)),
    .temperature (in_tdata),
    .limits      (limits),
    .result      (step_result)
  );

  // Result register with skid entry.
  tah_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (step_result),
    .can_push  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_result)
  );

  assign out_tdata = OutDataW'(out_result);

  // Checks.
  `TAH_ASSERT_NOW(a_skid_needs_full_out, clk, rst_n, !in_tready, out_tvalid, "skid full with empty output")
  `TAH_ASSERT_NEXT(a_result_lands, clk, rst_n, in_accept && !out_tvalid, out_tvalid, "accepted reading gave no result")
  `TAH_ASSERT_NEXT(a_restart_result, clk, rst_n, in_accept && in_tuser && (!out_tvalid || out_tready), out_tdata[4:0] == {LED_KEEP, EV_NONE}, "restart result is not none / unchanged")

endmodule
